[hdl/accc_pkg.sv]
// Shared types, constants and the character decoder of the column conservation classifier.
package accc_pkg;

  // Counting limits and register geometry
  localparam int unsigned MAX_SPECIES = 256;
  localparam int unsigned NUM_BASES   = 5;
  localparam int unsigned BASE_IDX_W  = 3;
  localparam int unsigned THR_W       = 17;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CLASS_W     = 2;

  localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_THRESHOLD  = 1'b0,
    CFG_OUT_THRESHOLD = 1'b1
  } cfg_idx_e;

  // Conservation classes
  typedef enum logic [CLASS_W-1:0] {
    CLASS_NONE    = 2'd0,
    CLASS_IN_ONLY = 2'd1,
    CLASS_BOTH    = 2'd2
  } class_e;

  // Decoded character slot: five counted bases, other, and ignored
  typedef enum logic [BASE_IDX_W-1:0] {
    SLOT_A     = 3'd0,
    SLOT_G     = 3'd1,
    SLOT_C     = 3'd2,
    SLOT_T     = 3'd3,
    SLOT_GAP   = 3'd4,
    SLOT_OTHER = 3'd5,
    SLOT_SKIP  = 3'd6
  } slot_e;

  // Majority and share check result of one group
  typedef struct packed {
    logic                  found;
    logic [BASE_IDX_W-1:0] idx;
    logic                  pass;
  } share_res_t;

  // Fold lower case and map a character onto its slot
  function automatic slot_e decode_char(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] up;
    slot_e             s;
    up = ch;
    if (ch inside {[8'h61:8'h7A]}) begin
      up = ch - 8'd32;
    end
    case (up)
      8'h41:   s = SLOT_A;
      8'h47:   s = SLOT_G;
      8'h43:   s = SLOT_C;
      8'h54:   s = SLOT_T;
      8'h2D:   s = SLOT_GAP;
      8'h4E:   s = SLOT_SKIP;
      default: s = SLOT_OTHER;
    endcase
    return s;
  endfunction

endpackage

[hdl/alignment_column_conservation_classifier.sv]
// Top level of the alignment column conservation classifier.
//
// Input channel: one character per transfer (base_char_i, from_in_group_i,
// column_end_i). Characters are counted per group; N is skipped, letters are
// case folded. The transfer that carries column_end_i closes the column.
// Output channel: one conservation_class_o transfer per closed column.
// Configuration: cfg_we_i writes cfg_data_i into the threshold selected by
// cfg_idx_i (0 in-group, 1 out-group).
// Path: the column-end transfer moves the counts into the column snapshot
// register, then through the majority pick and the 17 x count-width share
// multiply into the output register. Throughput is one character per cycle,
// also across column boundaries, as long as the receiver takes results.
// When the receiver stalls, the snapshot and output registers hold up to two
// finished columns; in_ready_o drops only while both are full.
// Reset clears all counts, the pipeline valid flags and sets both
// thresholds to 45875 (about 0.7).
module alignment_column_conservation_classifier #(
  parameter int unsigned MaxSpecies = accc_pkg::MAX_SPECIES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [accc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [accc_pkg::THR_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [accc_pkg::CHAR_W-1:0]     base_char_i,
  input  logic                            from_in_group_i,
  input  logic                            column_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [accc_pkg::CLASS_W-1:0]    conservation_class_o
);

  localparam int unsigned CntW = $clog2(MaxSpecies + 1);
  localparam int unsigned NB   = accc_pkg::NUM_BASES;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxSpecies);

  logic [accc_pkg::THR_W-1:0] in_thr_q, out_thr_q;

  logic [CntW-1:0] in_cnt_q  [NB];
  logic [CntW-1:0] out_cnt_q [NB];
  logic [CntW-1:0] in_cnt_d  [NB];
  logic [CntW-1:0] out_cnt_d [NB];
  logic [CntW-1:0] in_seen_q, in_seen_d, out_seen_q, out_seen_d;

  logic [CntW-1:0] snap_in_cnt_q  [NB];
  logic [CntW-1:0] snap_out_cnt_q [NB];
  logic [CntW-1:0] snap_in_seen_q, snap_out_seen_q;
  logic            snap_valid_q;
  logic            snap_adv;

  logic                         out_valid_q;
  logic [accc_pkg::CLASS_W-1:0] class_q;
  accc_pkg::class_e             class_d;

  logic            in_xfer;
  accc_pkg::slot_e slot;
  accc_pkg::share_res_t in_res, out_res;

  // Handshake
  assign snap_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !snap_valid_q || snap_adv;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign conservation_class_o = class_q;

  // Threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_thr_q  <= accc_pkg::THR_RESET;
      out_thr_q <= accc_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        accc_pkg::CFG_IN_THRESHOLD:  in_thr_q  <= cfg_data_i;
        accc_pkg::CFG_OUT_THRESHOLD: out_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance counts by the incoming character, saturating at the species limit
  assign slot = accc_pkg::decode_char(base_char_i);

  always_comb begin
    in_cnt_d   = in_cnt_q;
    out_cnt_d  = out_cnt_q;
    in_seen_d  = in_seen_q;
    out_seen_d = out_seen_q;
    if (slot != accc_pkg::SLOT_SKIP) begin
      if (from_in_group_i) begin
        if (in_seen_q < CntMax) in_seen_d = in_seen_q + CntW'(1);
      end else begin
        if (out_seen_q < CntMax) out_seen_d = out_seen_q + CntW'(1);
      end
      for (int i = 0; i < int'(NB); i++) begin
        if (slot == accc_pkg::slot_e'(i)) begin
          if (from_in_group_i) begin
            if (in_cnt_q[i] < CntMax) in_cnt_d[i] = in_cnt_q[i] + CntW'(1);
          end else begin
            if (out_cnt_q[i] < CntMax) out_cnt_d[i] = out_cnt_q[i] + CntW'(1);
          end
        end
      end
    end
  end

  // Hold and update counts; clear them when a column closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NB); i++) begin
        in_cnt_q[i]  <= '0;
        out_cnt_q[i] <= '0;
      end
      in_seen_q  <= '0;
      out_seen_q <= '0;
    end else if (in_xfer) begin
      if (column_end_i) begin
        for (int i = 0; i < int'(NB); i++) begin
          in_cnt_q[i]  <= '0;
          out_cnt_q[i] <= '0;
        end
        in_seen_q  <= '0;
        out_seen_q <= '0;
      end else begin
        in_cnt_q   <= in_cnt_d;
        out_cnt_q  <= out_cnt_d;
        in_seen_q  <= in_seen_d;
        out_seen_q <= out_seen_d;
      end
    end
  end

  // Snapshot the closed column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_xfer && column_end_i) begin
      snap_valid_q <= 1'b1;
    end else if (snap_adv) begin
      snap_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && column_end_i) begin
      snap_in_cnt_q   <= in_cnt_d;
      snap_out_cnt_q  <= out_cnt_d;
      snap_in_seen_q  <= in_seen_d;
      snap_out_seen_q <= out_seen_d;
    end
  end

  // Majority and share checks per group
  accc_share_check #(.CntW(CntW)) u_in_check (
    .counts_i (snap_in_cnt_q),
    .seen_i   (snap_in_seen_q),
    .thr_i    (in_thr_q),
    .res_o    (in_res)
  );

  accc_share_check #(.CntW(CntW)) u_out_check (
    .counts_i (snap_out_cnt_q),
    .seen_i   (snap_out_seen_q),
    .thr_i    (out_thr_q),
    .res_o    (out_res)
  );

  // Combine the group verdicts
  always_comb begin
    if (!in_res.found || !in_res.pass) begin
      class_d = accc_pkg::CLASS_NONE;
    end else if (!out_res.found || out_res.idx != in_res.idx || !out_res.pass) begin
      class_d = accc_pkg::CLASS_IN_ONLY;
    end else begin
      class_d = accc_pkg::CLASS_BOTH;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_adv) begin
      out_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_adv && snap_valid_q) begin
      class_q <= class_d;
    end
  end

endmodule

[hdl/accc_share_check.sv]
// Majority base pick and threshold share compare for one group of counts.
module accc_share_check #(
  parameter int unsigned CntW = 9
) (
  input  logic [CntW-1:0]                counts_i [accc_pkg::NUM_BASES],
  input  logic [CntW-1:0]                seen_i,
  input  logic [accc_pkg::THR_W-1:0]     thr_i,
  output accc_pkg::share_res_t           res_o
);

  localparam int unsigned ProdW = accc_pkg::THR_W + CntW;
  localparam int unsigned IdxW  = accc_pkg::BASE_IDX_W;

  logic [CntW-1:0]                  best;
  logic [accc_pkg::BASE_IDX_W-1:0]  best_idx;
  logic [ProdW-1:0]                 lhs;
  logic [ProdW-1:0]                 rhs;

  // Pick the strictly largest count, first base wins a tie
  always_comb begin
    best     = '0;
    best_idx = '0;
    for (int i = 0; i < int'(accc_pkg::NUM_BASES); i++) begin
      if (counts_i[i] > best) begin
        best     = counts_i[i];
        best_idx = IdxW'(i);
      end
    end
  end

  // Cross-multiply: count * one >= threshold * seen
  assign lhs = ProdW'({best, {accc_pkg::FRAC_W{1'b0}}});
  assign rhs = ProdW'(thr_i) * ProdW'(seen_i);

  assign res_o.found = (best != '0);
  assign res_o.idx   = best_idx;
  assign res_o.pass  = (lhs >= rhs);

endmodule
